>>> hw/rtl/tsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsa_pkg
// request and result types, command codes and constants of the slot allocator
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int TIME_W  = 32;
  localparam int OWNER_W = 8;
  localparam int ENTRY_W = OWNER_W + TIME_W;

  localparam logic [1:0] CMD_ADVANCE  = 2'd0;
  localparam logic [1:0] CMD_ALLOCATE = 2'd1;
  localparam logic [1:0] CMD_INSPECT  = 2'd2;

  localparam logic [OWNER_W-1:0] FREE_TAG  = 8'd42;
  localparam logic [TIME_W-1:0]  CLOCK_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] elapsed;
    logic [7:0]  owner_tag;
    logic [6:0]  request_size;
    logic [15:0] duration;
    logic [5:0]  slot_index;
  } tsa_req_t;

  typedef struct packed {
    logic        granted;
    logic [6:0]  freed_count;
    logic [6:0]  free_slots;
    logic [6:0]  busy_slots;
    logic        slot_busy;
    logic [7:0]  slot_owner;
    logic [31:0] slot_expiry;
    logic [31:0] now_time;
  } tsa_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/tsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsa_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module tsa_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [AddrW-1:0]             waddr_i,
  input  wire logic [WIDTH-1:0]             wdata_i,
  input  wire logic [AddrW-1:0]             raddr_i,
  output      logic [WIDTH-1:0]             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hw/rtl/timed_slot_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_slot_allocator_core
// pool of timed slots with allocate, advance-and-expire and inspect requests
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result is ready, and the result appears on res_o for exactly one
// cycle with done_o high. The receiver cannot hold results off, so sample
// res_o whenever done_o is set. One request is worked on at a time. An advance
// reads every slot's expiry out of the slot table one slot per cycle and frees
// the slots that have expired; an allocate walks the slots one per cycle until
// enough free slots have been stamped, while refusals and zero-size requests
// finish without a walk; an inspect waits for the registered table read; an
// unknown command finishes without touching the pool. A write to the pool size
// register (the user must write it only while idle; the block does not
// enforce it) clears the pool and the clock at once - no clearing pass is
// needed, per-slot busy and written flags sit in flip-flops.
// ----------------------------------------------------------------------------
module timed_slot_allocator_core
  import tsa_pkg::*;
#(
  parameter int MAX_SLOTS = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output      logic     busy,
  input  wire tsa_req_t req_i,
  output      logic     done_o,
  output      tsa_res_t res_o,
  input  wire logic     cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i
);

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;  // slot index
  localparam int CW = $clog2(MAX_SLOTS + 1);                       // slot count

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_ADV   = 3'd2;
  localparam logic [2:0] ST_ALLOC = 3'd3;
  localparam logic [2:0] ST_INSP  = 3'd4;

  // sequencer and pool state
  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        n_q, n_d;          // managed pool size
  logic [CW-1:0]        free_q, free_d;
  logic [TIME_W-1:0]    clock_q, clock_d;
  logic [MAX_SLOTS-1:0] busy_q, busy_d;    // slot occupied
  logic [MAX_SLOTS-1:0] wr_q, wr_d;        // slot table entry written since clear
  logic [CW-1:0]        cnt_q, cnt_d;      // sweep position
  logic                 chk_v_q, chk_v_d;  // read data in flight for the sweep
  logic [IW-1:0]        chk_idx_q, chk_idx_d;
  logic [6:0]           taken_q, taken_d;
  logic [6:0]           freed_q, freed_d;
  logic                 done_q, done_d;

  // payload
  tsa_req_t             req_q, req_d;
  logic [TIME_W-1:0]    exp_q, exp_d;
  tsa_res_t             res_q, res_d;

  // shared saturating adder, clock plus elapsed or duration
  logic [15:0]          add_b;
  logic [TIME_W:0]      add_sum;
  logic [TIME_W-1:0]    add_sat;

  // slot table ports
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [IW-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  // pool size register value, out-of-range values clamped
  logic [6:0]           cfg_clamp;
  logic [CW-1:0]        cfg_n;

  // result assembly
  logic                 fin;
  logic                 fin_granted;
  logic                 fin_sbusy;
  logic [OWNER_W-1:0]   fin_owner;
  logic [TIME_W-1:0]    fin_exp;
  logic                 insp_in_range;
  logic [IW-1:0]        insp_idx;

  assign add_b   = (req_q.cmd == CMD_ADVANCE) ? req_q.elapsed : req_q.duration;
  assign add_sum = {1'b0, clock_q} + {{(TIME_W - 16 + 1){1'b0}}, add_b};
  assign add_sat = add_sum[TIME_W] ? CLOCK_MAX : add_sum[TIME_W-1:0];

  always_comb begin
    if (cfg_wdata_i == 7'd0) begin
      cfg_clamp = 7'd1;
    end else if (cfg_wdata_i > 7'(MAX_SLOTS)) begin
      cfg_clamp = 7'(MAX_SLOTS);
    end else begin
      cfg_clamp = cfg_wdata_i;
    end
  end
  assign cfg_n = CW'(cfg_clamp);

  assign insp_idx      = req_q.slot_index[IW-1:0];
  assign insp_in_range = ({1'b0, req_q.slot_index} < 7'(n_q));

  // the read port follows the inspect index while idle, else the sweep
  assign ram_raddr = (state_q == ST_IDLE) ? req_i.slot_index[IW-1:0] : cnt_q[IW-1:0];

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    free_d      = free_q;
    clock_d     = clock_q;
    busy_d      = busy_q;
    wr_d        = wr_q;
    cnt_d       = cnt_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = chk_idx_q;
    taken_d     = taken_q;
    freed_d     = freed_q;
    req_d       = req_q;
    exp_d       = exp_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[IW-1:0];
    ram_wdata   = {req_q.owner_tag, exp_q};
    fin         = 1'b0;
    fin_granted = 1'b0;
    fin_sbusy   = 1'b0;
    fin_owner   = '0;
    fin_exp     = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d   = req_i;
          cnt_d   = '0;
          taken_d = '0;
          freed_d = '0;
          state_d = (req_i.cmd == CMD_INSPECT) ? ST_INSP : ST_ADD;
        end
      end

      ST_ADD: begin
        case (req_q.cmd)
          CMD_ADVANCE: begin
            clock_d = add_sat;
            state_d = ST_ADV;
          end
          CMD_ALLOCATE: begin
            exp_d = add_sat;
            if (req_q.request_size > 7'(free_q)) begin
              fin = 1'b1;
            end else if (req_q.request_size == 7'd0) begin
              fin         = 1'b1;
              fin_granted = 1'b1;
            end else begin
              state_d = ST_ALLOC;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      // read slot cnt, check the slot read in the previous cycle
      ST_ADV: begin
        if (cnt_q < n_q) begin
          chk_v_d   = 1'b1;
          chk_idx_d = cnt_q[IW-1:0];
          cnt_d     = cnt_q + CW'(1);
        end
        if (chk_v_q) begin
          if (busy_q[chk_idx_q] && (ram_rdata[TIME_W-1:0] <= clock_q)) begin
            busy_d[chk_idx_q] = 1'b0;
            freed_d           = freed_q + 7'd1;
            if (free_q < n_q) begin
              free_d = free_q + CW'(1);
            end
          end
        end else if (cnt_q >= n_q) begin
          fin = 1'b1;
        end
      end

      // stamp free slots in order until the request is met
      ST_ALLOC: begin
        if (!busy_q[cnt_q[IW-1:0]]) begin
          ram_we                 = 1'b1;
          busy_d[cnt_q[IW-1:0]]  = 1'b1;
          wr_d[cnt_q[IW-1:0]]    = 1'b1;
          taken_d                = taken_q + 7'd1;
          free_d                 = free_q - CW'(1);
        end
        cnt_d = cnt_q + CW'(1);
        if ((taken_d == req_q.request_size) || (cnt_d >= n_q)) begin
          fin         = 1'b1;
          fin_granted = 1'b1;
        end
      end

      ST_INSP: begin
        fin = 1'b1;
        if (insp_in_range) begin
          fin_sbusy = busy_q[insp_idx];
          fin_owner = busy_q[insp_idx] ? ram_rdata[ENTRY_W-1:TIME_W] : FREE_TAG;
          fin_exp   = wr_q[insp_idx] ? ram_rdata[TIME_W-1:0] : '0;
        end else begin
          fin_owner = FREE_TAG;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // pool size write re-initialises the pool
    if (cfg_we_i) begin
      n_d     = cfg_n;
      free_d  = cfg_n;
      clock_d = '0;
      busy_d  = '0;
      wr_d    = '0;
    end

    done_d = fin;
    res_d  = res_q;
    if (fin) begin
      state_d           = ST_IDLE;
      res_d.granted     = fin_granted;
      res_d.freed_count = freed_d;
      res_d.free_slots  = 7'(free_d);
      res_d.busy_slots  = 7'(n_q - free_d);
      res_d.slot_busy   = fin_sbusy;
      res_d.slot_owner  = fin_owner;
      res_d.slot_expiry = fin_exp;
      res_d.now_time    = clock_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_q       <= CW'(MAX_SLOTS);
      free_q    <= CW'(MAX_SLOTS);
      clock_q   <= '0;
      busy_q    <= '0;
      wr_q      <= '0;
      cnt_q     <= '0;
      chk_v_q   <= 1'b0;
      chk_idx_q <= '0;
      taken_q   <= '0;
      freed_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      free_q    <= free_d;
      clock_q   <= clock_d;
      busy_q    <= busy_d;
      wr_q      <= wr_d;
      cnt_q     <= cnt_d;
      chk_v_q   <= chk_v_d;
      chk_idx_q <= chk_idx_d;
      taken_q   <= taken_d;
      freed_q   <= freed_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    exp_q <= exp_d;
    res_q <= res_d;
  end

  // owner tag and expiry per slot
  tsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // free count never exceeds the pool
  a_free_le_pool : assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= n_q)
    else $error("free count above pool size");

  // an occupied slot always has a written table entry
  a_busy_written : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q & ~wr_q) == '0)
    else $error("busy slot without table entry");

  // while idle the busy marks and the free count agree
  a_count_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(busy_q) == (int'(n_q) - int'(free_q))))
    else $error("busy marks disagree with free count");

  // a result strobe comes only as the sequencer returns to idle
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ((state_q == ST_IDLE) && ($past(state_q) != ST_IDLE)))
    else $error("result strobe outside request completion");

endmodule
`default_nettype wire

>>> test/timed_slot_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_slot_allocator_core_tb
// self-checking bench for the timed slot allocator: directed corner requests,
// pool size extremes and long random traffic, each result checked against
// an in-bench model of the slot table, clock and free count
// ----------------------------------------------------------------------------
module timed_slot_allocator_core_tb;
  import tsa_pkg::*;

  localparam int          POOL_MAX    = 64;
  localparam logic [1:0]  CMD_UNKNOWN = 2'd3;
  localparam int          RANDOM_REQS = 1512;
  localparam int          PHASES      = 6;
  localparam int          TIMEOUT_NS  = 20_000_000;
  localparam logic [7:0]  TAG_H       = 8'h48;
  localparam logic [7:0]  TAG_P       = 8'h50;
  localparam logic [7:0]  TAG_STAR    = 8'h2A;

  // dut inputs, all driven to known values from time zero
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  tsa_req_t    req_i       = '0;
  logic        done_o;
  tsa_res_t    res_o;
  logic        cfg_we_i    = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;

  // model of the slot table
  logic        table_busy   [POOL_MAX];
  logic [7:0]  table_owner  [POOL_MAX];
  logic [31:0] table_expiry [POOL_MAX];
  logic [31:0] now_clock;
  int          free_count;
  int          pool_size;

  // predicted results, oldest first
  tsa_res_t    expected_results [$];

  // bookkeeping
  int  mismatches     = 0;
  int  unexpected     = 0;
  int  requests_sent  = 0;
  int  results_seen   = 0;
  int  settings_used  = 0;
  int  grants         = 0;
  int  refusals       = 0;
  int  slots_freed    = 0;
  bit  idle_on        = 1'b1;

  timed_slot_allocator_core #(
    .MAX_SLOTS   (POOL_MAX)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model --

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? CLOCK_MAX : sum[31:0];
  endfunction

  // size write clears the pool and the clock; 0 reads as 1, above 64 as 64
  function automatic void apply_pool_size(input logic [6:0] value);
    pool_size = int'(value);
    if (pool_size == 0) pool_size = 1;
    if (pool_size > POOL_MAX) pool_size = POOL_MAX;
    for (int i = 0; i < POOL_MAX; i++) begin
      table_busy[i]   = 1'b0;
      table_owner[i]  = FREE_TAG;
      table_expiry[i] = '0;
    end
    now_clock  = '0;
    free_count = pool_size;
  endfunction

  function automatic tsa_res_t predict_result(input tsa_req_t r);
    tsa_res_t    res;
    logic [31:0] stamp;
    int          freed;
    int          taken;
    res   = '0;
    freed = 0;
    taken = 0;
    case (r.cmd)
      CMD_ADVANCE: begin
        now_clock = sat_add(now_clock, 32'(r.elapsed));
        for (int i = 0; i < pool_size; i++) begin
          // expiry at or before the clock frees the slot, the expiry stays stored
          if (table_busy[i] && table_expiry[i] <= now_clock) begin
            table_busy[i]  = 1'b0;
            table_owner[i] = FREE_TAG;
            freed++;
          end
        end
        free_count += freed;
        if (free_count > pool_size) free_count = pool_size;
        res.freed_count = 7'(freed);
        slots_freed += freed;
      end
      CMD_ALLOCATE: begin
        if (int'(r.request_size) <= free_count) begin
          stamp       = sat_add(now_clock, 32'(r.duration));
          res.granted = 1'b1;
          // lowest free slots first, not necessarily contiguous
          for (int i = 0; i < pool_size && taken < int'(r.request_size); i++) begin
            if (!table_busy[i]) begin
              table_busy[i]   = 1'b1;
              table_owner[i]  = r.owner_tag;
              table_expiry[i] = stamp;
              taken++;
            end
          end
          free_count -= taken;
          grants++;
        end else begin
          refusals++;
        end
      end
      CMD_INSPECT: begin
        if (int'(r.slot_index) < pool_size) begin
          res.slot_busy   = table_busy[r.slot_index];
          res.slot_owner  = table_owner[r.slot_index];
          res.slot_expiry = table_expiry[r.slot_index];
        end else begin
          res.slot_owner  = FREE_TAG;
        end
      end
      default: ;
    endcase
    res.free_slots = 7'(free_count);
    res.busy_slots = 7'(pool_size - free_count);
    res.now_time   = now_clock;
    return res;
  endfunction

  // ------------------------------------------------------------- drivers --

  function automatic tsa_req_t make_request(input logic [1:0] cmd, input logic [15:0] elapsed,
                                            input logic [7:0] owner, input logic [6:0] size,
                                            input logic [15:0] dur, input logic [5:0] idx);
    tsa_req_t r;
    r.cmd          = cmd;
    r.elapsed      = elapsed;
    r.owner_tag    = owner;
    r.request_size = size;
    r.duration     = dur;
    r.slot_index   = idx;
    return r;
  endfunction

  // called at a rising edge; returns at the accepting edge or after a gap
  task automatic send_request(input tsa_req_t r);
    start <= 1'b1;
    req_i <= r;
    // busy sampled mid-cycle, it only moves on a rising edge
    do @(negedge clk_i); while (busy !== 1'b0);
    @(posedge clk_i);
    expected_results.push_back(predict_result(r));
    requests_sent++;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pool_size(input logic [6:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    apply_pool_size(value);
    settings_used++;
  endtask

  // shaped random request: mostly sensible sizes and lifetimes so that the
  // pool fills, expires and refills; the unused fields carry random noise
  function automatic tsa_req_t random_request();
    tsa_req_t    r;
    int unsigned pick;
    int unsigned cap;
    r.cmd          = 2'($urandom);
    r.elapsed      = 16'($urandom);
    r.owner_tag    = 8'($urandom);
    r.request_size = 7'($urandom);
    r.duration     = 16'($urandom);
    r.slot_index   = 6'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.cmd = CMD_ALLOCATE;
      cap   = (free_count < 6) ? free_count : 6;
      case ($urandom_range(0, 9))
        6:       r.request_size = 7'(free_count);
        7:       r.request_size = 7'(free_count + 1);
        8:       r.request_size = 7'($urandom_range(0, 127));
        9:       r.request_size = '0;
        default: r.request_size = 7'($urandom_range(0, cap));
      endcase
      case ($urandom_range(0, 15))
        0:       r.duration = '0;
        1, 2:    r.duration = 16'($urandom_range(0, 65535));
        default: r.duration = 16'($urandom_range(0, 300));
      endcase
    end else if (pick < 70) begin
      r.cmd = CMD_ADVANCE;
      if ($urandom_range(0, 9) != 0) r.elapsed = 16'($urandom_range(0, 80));
    end else if (pick < 95) begin
      r.cmd = CMD_INSPECT;
      if ($urandom_range(0, 4) != 0) r.slot_index = 6'($urandom_range(0, pool_size - 1));
    end else begin
      r.cmd = CMD_UNKNOWN;
    end
    return r;
  endfunction

  // -------------------------------------------------------------- checker --

  always @(negedge clk_i) begin : check_results
    tsa_res_t want;
    if (rst_ni && done_o === 1'b1) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("result %0d arrived with nothing outstanding", results_seen);
      end else begin
        want = expected_results.pop_front();
        if (res_o.granted     !== want.granted     || res_o.freed_count !== want.freed_count ||
            res_o.free_slots  !== want.free_slots  || res_o.busy_slots  !== want.busy_slots  ||
            res_o.slot_busy   !== want.slot_busy   || res_o.slot_owner  !== want.slot_owner  ||
            res_o.slot_expiry !== want.slot_expiry || res_o.now_time    !== want.now_time) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display({"result %0d: want gr=%0d fr=%0d free=%0d busy=%0d sb=%0d own=%0h ",
                      "exp=%0h now=%0h, got gr=%0d fr=%0d free=%0d busy=%0d sb=%0d own=%0h ",
                      "exp=%0h now=%0h"}, results_seen,
                     want.granted, want.freed_count, want.free_slots, want.busy_slots,
                     want.slot_busy, want.slot_owner, want.slot_expiry, want.now_time,
                     res_o.granted, res_o.freed_count, res_o.free_slots, res_o.busy_slots,
                     res_o.slot_busy, res_o.slot_owner, res_o.slot_expiry, res_o.now_time);
        end
      end
    end
  end

  // ----------------------------------------------------------------- tests --

  // reset contents, zero-size and full grants, refusal, expiry on equality,
  // freed slot keeping its expiry, scattered allocation and zero lifetime
  task automatic test_reset_and_grants();
    send_request(make_request(CMD_INSPECT,  16'd0,     8'h00,    7'd0,   16'd0,     6'd0));
    send_request(make_request(CMD_INSPECT,  16'd0,     8'h00,    7'd0,   16'd0,     6'd63));
    send_request(make_request(CMD_UNKNOWN,  16'hFFFF,  8'hFF,    7'd127, 16'hFFFF,  6'd63));
    send_request(make_request(CMD_ADVANCE,  16'd0,     8'h00,    7'd0,   16'd0,     6'd0));
    send_request(make_request(CMD_ALLOCATE, 16'd0,     8'hA5,    7'd0,   16'd100,   6'd0));
    send_request(make_request(CMD_ALLOCATE, 16'd0,     8'hFF,    7'd64,  16'hFFFF,  6'd0));
    send_request(make_request(CMD_ALLOCATE, 16'd0,     8'h11,    7'd1,   16'd5,     6'd0));
    send_request(make_request(CMD_INSPECT,  16'd0,     8'h00,    7'd0,   16'd0,     6'd63));
    send_request(make_request(CMD_ADVANCE,  16'd65534, 8'h00,    7'd0,   16'd0,     6'd0));
    // clock now equals every expiry, the whole pool goes
    send_request(make_request(CMD_ADVANCE,  16'd1,     8'h00,    7'd0,   16'd0,     6'd0));
    send_request(make_request(CMD_INSPECT,  16'd0,     8'h00,    7'd0,   16'd0,     6'd5));
    send_request(make_request(CMD_ALLOCATE, 16'd0,     8'h33,    7'd127, 16'd10,    6'd0));
    send_request(make_request(CMD_ALLOCATE, 16'd0,     TAG_H,    7'd3,   16'd10,    6'd0));
    send_request(make_request(CMD_ALLOCATE, 16'd0,     TAG_P,    7'd3,   16'd1000,  6'd0));
    send_request(make_request(CMD_ADVANCE,  16'd20,    8'h00,    7'd0,   16'd0,     6'd0));
    // the gap left by the first three plus slots past the second block
    send_request(make_request(CMD_ALLOCATE, 16'd0,     8'h00,    7'd5,   16'd0,     6'd0));
    send_request(make_request(CMD_INSPECT,  16'd0,     8'h00,    7'd0,   16'd0,     6'd7));
    send_request(make_request(CMD_ADVANCE,  16'd0,     8'h00,    7'd0,   16'd0,     6'd0));
    send_request(make_request(CMD_ALLOCATE, 16'd0,     TAG_STAR, 7'd60,  16'hFFFF,  6'd0));
    send_request(make_request(CMD_INSPECT,  16'd0,     8'h00,    7'd0,   16'd0,     6'd63));
    send_request(make_request(CMD_INSPECT,  16'd0,     8'h00,    7'd0,   16'd0,     6'd62));
  endtask

  // size register clamping, inspect past the end of the pool
  task automatic test_pool_limits();
    write_pool_size(7'd0);
    send_request(make_request(CMD_INSPECT,  16'd0, 8'h00, 7'd0,  16'd0, 6'd0));
    send_request(make_request(CMD_INSPECT,  16'd0, 8'h00, 7'd0,  16'd0, 6'd1));
    send_request(make_request(CMD_ALLOCATE, 16'd0, 8'h77, 7'd2,  16'd5, 6'd0));
    send_request(make_request(CMD_ALLOCATE, 16'd0, TAG_P, 7'd1,  16'd5, 6'd0));
    send_request(make_request(CMD_ADVANCE,  16'd3, 8'h00, 7'd0,  16'd0, 6'd0));
    send_request(make_request(CMD_ADVANCE,  16'd2, 8'h00, 7'd0,  16'd0, 6'd0));
    send_request(make_request(CMD_INSPECT,  16'd0, 8'h00, 7'd0,  16'd0, 6'd0));
    send_request(make_request(CMD_UNKNOWN,  16'd9, 8'h01, 7'd1,  16'd9, 6'd0));
    write_pool_size(7'd127);
    send_request(make_request(CMD_ALLOCATE, 16'd0, 8'h5A, 7'd64, 16'd7, 6'd0));
    send_request(make_request(CMD_INSPECT,  16'd0, 8'h00, 7'd0,  16'd0, 6'd63));
    write_pool_size(7'd65);
    send_request(make_request(CMD_ALLOCATE, 16'd0, 8'hC3, 7'd10, 16'd7, 6'd0));
    send_request(make_request(CMD_INSPECT,  16'd0, 8'h00, 7'd0,  16'd0, 6'd9));
    send_request(make_request(CMD_INSPECT,  16'd0, 8'h00, 7'd0,  16'd0, 6'd10));
    write_pool_size(7'd7);
    send_request(make_request(CMD_INSPECT,  16'd0, 8'h00, 7'd0,  16'd0, 6'd7));
  endtask

  // random traffic over several pool sizes; the last phase runs flat out
  task automatic test_random_traffic();
    logic [6:0] size_value;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       size_value = 7'd64;
        1:       size_value = 7'd1;
        2:       size_value = 7'($urandom_range(2, 63));
        3:       size_value = 7'($urandom_range(0, 127));
        4:       size_value = 7'($urandom_range(2, 12));
        default: size_value = 7'd64;
      endcase
      write_pool_size(size_value);
      for (int n = 0; n < RANDOM_REQS / PHASES; n++) begin
        if (phase == PHASES - 1)
          idle_on = 1'b0;
        else if (n % 32 == 0)
          idle_on = ($urandom_range(0, 2) != 0);
        // now and then hold back until the block has caught up
        if (phase != PHASES - 1 && $urandom_range(0, 49) == 0) wait_drained();
        send_request(random_request());
      end
    end
  endtask

  // ------------------------------------------------------------ sequence --

  initial begin
    apply_pool_size(7'd64);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_and_grants();
    test_pool_limits();
    test_random_traffic();

    wait_drained();
    repeat (POOL_MAX + 8) @(posedge clk_i);

    $display("sent %0d requests over %0d pool size settings, %0d results came back",
             requests_sent, settings_used, results_seen);
    $display("grants %0d, refusals %0d, slots expired %0d, mismatches %0d, strays %0d",
             grants, refusals, slots_freed, mismatches, unexpected);
    if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0) begin
      $display("timed_slot_allocator_core: match");
    end else begin
      $display("timed_slot_allocator_core: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("watchdog expired with %0d results outstanding", expected_results.size());
    $display("timed_slot_allocator_core: mismatch");
    $finish;
  end

endmodule
